### hdl/max_priority_queue_heap_top_macros.svh
// assertion macros for the max priority queue
// used by max_priority_queue_heap_top, expects clk and rst in scope
`ifndef MAX_PRIORITY_QUEUE_HEAP_TOP_MACROS_SVH
`define MAX_PRIORITY_QUEUE_HEAP_TOP_MACROS_SVH

// same-cycle implication
`define MPQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MPQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/mpq_pkg.sv
// types and constants for the max priority queue
// no dependencies
`timescale 1ns / 1ps

package mpq_pkg;

  localparam int DEPTH = 64;
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef logic signed [31:0] val_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_POP  = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic  en;
    logic  pop;
    val_t  value;
  } cell_ctl_t;

endpackage

### hdl/mpq_cell.sv
// one cell of the sorted chain: holds one entry, shifts or inserts
// depends on mpq_pkg
`timescale 1ns / 1ps

module mpq_cell (
  input  logic              clk,
  input  mpq_pkg::cell_ctl_t ctl,
  input  logic              occupied,
  input  mpq_pkg::val_t     left_data,
  input  logic              left_gt,
  input  mpq_pkg::val_t     right_data,
  output mpq_pkg::val_t     data,
  output logic              gt
);

  mpq_pkg::val_t data_next;

  // new word belongs at or before this cell
  assign gt = !occupied || (ctl.value > data);

  always_comb begin
    data_next = data;
    if (ctl.en) begin
      if (ctl.pop) begin
        data_next = right_data;
      end else if (gt && left_gt) begin
        data_next = left_data;
      end else if (gt) begin
        data_next = ctl.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

### hdl/mpq_chain.sv
// row of DEPTH cells kept sorted largest first, cell 0 holds the maximum
// depends on mpq_pkg, mpq_cell
`timescale 1ns / 1ps

module mpq_chain (
  input  logic               clk,
  input  mpq_pkg::cell_ctl_t ctl,
  input  mpq_pkg::cnt_t      count,
  output mpq_pkg::val_t      top_data
);

  mpq_pkg::val_t data [mpq_pkg::DEPTH];
  logic [mpq_pkg::DEPTH-1:0] gt;
  logic [mpq_pkg::DEPTH-1:0] occ;

  for (genvar i = 0; i < mpq_pkg::DEPTH; i++) begin : g_cell
    mpq_pkg::val_t left_d;
    mpq_pkg::val_t right_d;
    logic          left_g;

    assign occ[i] = mpq_pkg::cnt_t'(i) < count;

    if (i == 0) begin : g_first
      assign left_d = ctl.value;
      assign left_g = 1'b0;
    end else begin : g_mid
      assign left_d = data[i-1];
      assign left_g = gt[i-1];
    end

    if (i == mpq_pkg::DEPTH - 1) begin : g_last
      assign right_d = data[i];
    end else begin : g_inner
      assign right_d = data[i+1];
    end

    mpq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occupied   (occ[i]),
      .left_data  (left_d),
      .left_gt    (left_g),
      .right_data (right_d),
      .data       (data[i]),
      .gt         (gt[i])
    );
  end

  assign top_data = data[0];

endmodule

### hdl/max_priority_queue_heap_top.sv
// max priority queue of signed 32-bit words, push or pop per input word
// depends on mpq_pkg, mpq_chain, max_priority_queue_heap_top_macros.svh
`timescale 1ns / 1ps
//
//  channel  handshake          fields
//  -------  -----------------  -----------------------------------
//  in       in_valid/in_ready  action, value
//  out      out_valid/out_ready top_value, count, is_empty, status
//
//  each word is captured in S_IDLE and executed in S_EXEC, where every cell of
//  the chain shifts or inserts in parallel against the broadcast value.
//  the result stays in the cells and count registers until taken; a new
//  word may be captured while it waits, and executes when out is free.
//  rst clears count, status, state and out_valid; cell contents need no reset.

`include "max_priority_queue_heap_top_macros.svh"

module max_priority_queue_heap_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                action,
  input  logic signed [31:0]  value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  top_value,
  output logic [6:0]          count,
  output logic                is_empty,
  output logic [1:0]          status
);

  mpq_pkg::state_t    state;
  mpq_pkg::state_t    state_next;
  mpq_pkg::action_t   act;
  mpq_pkg::val_t      val;
  mpq_pkg::cnt_t      cnt;
  mpq_pkg::status_t   st;
  mpq_pkg::cell_ctl_t ctl;
  mpq_pkg::val_t      top_data;

  logic fire;
  logic do_push;
  logic do_pop;

  assign do_push = (act == mpq_pkg::ACT_PUSH) && (cnt < mpq_pkg::cnt_t'(mpq_pkg::DEPTH));
  assign do_pop  = (act == mpq_pkg::ACT_POP) && (cnt != '0);

  always_comb begin
    state_next = state;
    unique case (state)
      mpq_pkg::S_IDLE: if (in_valid) state_next = mpq_pkg::S_EXEC;
      mpq_pkg::S_EXEC: if (!out_valid || out_ready) state_next = mpq_pkg::S_IDLE;
      default:         state_next = mpq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    fire     = 1'b0;
    unique case (state)
      mpq_pkg::S_IDLE: in_ready = 1'b1;
      mpq_pkg::S_EXEC: fire = !out_valid || out_ready;
      default:         in_ready = 1'b0;
    endcase
  end

  assign ctl.en    = fire && (do_push || do_pop);
  assign ctl.pop   = (act == mpq_pkg::ACT_POP);
  assign ctl.value = val;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mpq_pkg::S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
      st        <= mpq_pkg::ST_OK;
    end else begin
      state <= state_next;
      if (fire) begin
        out_valid <= 1'b1;
        if (do_push) begin
          cnt <= cnt + 1'b1;
          st  <= mpq_pkg::ST_OK;
        end else if (do_pop) begin
          cnt <= cnt - 1'b1;
          st  <= mpq_pkg::ST_OK;
        end else if (act == mpq_pkg::ACT_PUSH) begin
          st <= mpq_pkg::ST_FULL;
        end else begin
          st <= mpq_pkg::ST_EMPTY;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // captured word
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      act <= mpq_pkg::action_t'(action);
      val <= value;
    end
  end

  mpq_chain u_chain (
    .clk      (clk),
    .ctl      (ctl),
    .count    (cnt),
    .top_data (top_data)
  );

  assign top_value = (cnt == '0) ? '0 : top_data;
  assign count     = cnt;
  assign is_empty  = (cnt == '0);
  assign status    = st;

  `MPQ_ASSERT_IMP(a_cnt_bound, 1'b1, cnt <= mpq_pkg::cnt_t'(mpq_pkg::DEPTH),
                  "count above depth")
  `MPQ_ASSERT_IMP(a_full_flag, out_valid && st == mpq_pkg::ST_FULL,
                  cnt == mpq_pkg::cnt_t'(mpq_pkg::DEPTH), "full status with room left")
  `MPQ_ASSERT_IMP(a_empty_flag, out_valid && st == mpq_pkg::ST_EMPTY, cnt == '0,
                  "empty status with entries")
  `MPQ_ASSERT_NXT(a_push_cnt, fire && do_push, cnt == $past(cnt) + 1'b1,
                  "push did not grow count")

endmodule
